### hw/rtl/sedd_pkg.sv
// ----------------------------------------------------------------------------
// sedd_pkg: shared types and constants of the serpentine dither
// Word layouts, geometry limits, fixed-point scales and saturation helper.
// ----------------------------------------------------------------------------
package sedd_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int CfgW      = 11;
  localparam int CfgIdxW   = 1;
  localparam int ChanNum   = 3;
  localparam int ErrW      = 16;
  localparam int LineW     = ChanNum * ErrW;

  // code<<4 scale: full scale and threshold
  localparam logic signed [16:0] FullScale = 17'sd4080;
  localparam logic signed [15:0] HalfScale = 16'sd2040;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic            red_on;
    logic            green_on;
    logic            blue_on;
    logic [AddrW-1:0] column;
    logic [RowW-1:0]  row;
    logic            frame_end;
  } pix_out_t;

  // position and neighbor flags of one pixel
  typedef struct packed {
    logic [AddrW-1:0] x;
    logic [RowW-1:0]  y;
    logic             behind;
    logic             ahead;
    logic             down;
    logic             y_nz;
    logic             row_clr;
  } scan_t;

  typedef logic [ChanNum-1:0][ErrW-1:0] err_vec_t;

  function automatic logic signed [ErrW-1:0] sat16(input logic signed [17:0] v);
    logic signed [ErrW-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[ErrW-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/sedd_line_ram.sv
// ----------------------------------------------------------------------------
// sedd_line_ram: error line buffer
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module sedd_line_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [sedd_pkg::AddrW-1:0] waddr_i,
  input  sedd_pkg::err_vec_t        wdata_i,
  input  logic                      re_i,
  input  logic [sedd_pkg::AddrW-1:0] raddr_i,
  output sedd_pkg::err_vec_t        rdata_o
);

  sedd_pkg::err_vec_t mem [sedd_pkg::MaxWidth];
  sedd_pkg::err_vec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/sedd_scan.sv
// ----------------------------------------------------------------------------
// sedd_scan: geometry registers and serpentine scan counters
// Gives column, row and neighbor flags of the next pixel; advance per word.
// ----------------------------------------------------------------------------
module sedd_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sedd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sedd_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        advance_i,
  output sedd_pkg::scan_t             pos_o
);

  localparam int CW = sedd_pkg::CfgW;
  localparam int AW = sedd_pkg::AddrW;
  localparam int RW = sedd_pkg::RowW;

  logic [CW-1:0] width_q, height_q;
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [CW-1:0] w_eff, h_eff, y_pre, x_full;
  logic          wrap_pre;
  logic [AW-1:0] i_cur;
  logic [RW-1:0] y_cur;

  always_comb begin
    w_eff = (width_q == '0) ? CW'(1) :
            (width_q > CW'(sedd_pkg::MaxWidth)) ? CW'(sedd_pkg::MaxWidth) : width_q;
    h_eff = (height_q == '0) ? CW'(1) :
            (height_q > CW'(sedd_pkg::MaxHeight)) ? CW'(sedd_pkg::MaxHeight) : height_q;

    // geometry shrunk under the counters: start a new row
    wrap_pre = {1'b0, col_q} >= w_eff;
    i_cur    = wrap_pre ? '0 : col_q;
    y_pre    = wrap_pre ? ({1'b0, row_q} + CW'(1)) : {1'b0, row_q};
    y_cur    = (y_pre >= h_eff) ? '0 : y_pre[RW-1:0];
    x_full   = w_eff - CW'(1) - {1'b0, i_cur};

    pos_o.x       = y_cur[0] ? x_full[AW-1:0] : i_cur;
    pos_o.y       = y_cur;
    pos_o.behind  = i_cur != '0;
    pos_o.ahead   = ({1'b0, i_cur} + CW'(1)) < w_eff;
    pos_o.down    = ({1'b0, y_cur} + CW'(1)) < h_eff;
    pos_o.y_nz    = y_cur != '0;
    pos_o.row_clr = wrap_pre;

    if (pos_o.ahead) begin
      col_d = i_cur + AW'(1);
      row_d = y_cur;
    end else begin
      col_d = '0;
      row_d = pos_o.down ? (y_cur + RW'(1)) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(640);
      height_q <= CW'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sedd_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i;
        sedd_pkg::REG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### hw/rtl/sedd_diffuse.sv
// ----------------------------------------------------------------------------
// sedd_diffuse: per-channel threshold and error split
// Holds the sideways carry and the two partial down errors of the row.
// ----------------------------------------------------------------------------
module sedd_diffuse (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  sedd_pkg::pix_in_t               pix_i,
  input  sedd_pkg::scan_t                 pos_i,
  input  sedd_pkg::err_vec_t              line_i,
  output logic [sedd_pkg::ChanNum-1:0]    bits_o,
  output sedd_pkg::err_vec_t              back_o,
  output sedd_pkg::err_vec_t              near_o
);

  localparam int EW = sedd_pkg::ErrW;

  sedd_pkg::err_vec_t carry_q, near_q, far_q;
  sedd_pkg::err_vec_t carry_d, near_d, far_d;
  logic [sedd_pkg::ChanNum-1:0][7:0] pix;

  assign pix[0] = pix_i.red_in;
  assign pix[1] = pix_i.green_in;
  assign pix[2] = pix_i.blue_in;

  always_comb begin
    logic signed [EW-1:0] carry, near_old, far_old, line, v, c7, c3, c5, c1;
    logic signed [17:0]   sum;
    logic signed [16:0]   err;
    logic signed [19:0]   e20, p7, p3, p5;
    logic                 bit_on;
    for (int c = 0; c < sedd_pkg::ChanNum; c++) begin
      carry    = pos_i.row_clr ? '0 : $signed(carry_q[c]);
      near_old = pos_i.row_clr ? '0 : $signed(near_q[c]);
      far_old  = pos_i.row_clr ? '0 : $signed(far_q[c]);
      line     = pos_i.y_nz ? $signed(line_i[c]) : '0;

      sum = $signed({6'd0, pix[c], 4'd0}) + {{2{carry[EW-1]}}, carry}
          + {{2{line[EW-1]}}, line};
      v      = sedd_pkg::sat16(sum);
      bit_on = v > sedd_pkg::HalfScale;
      err    = {v[EW-1], v} - (bit_on ? sedd_pkg::FullScale : 17'sd0);

      // k/16 shares, floor by arithmetic shift
      e20 = {{3{err[16]}}, err};
      p7  = (e20 <<< 3) - e20;
      p3  = (e20 <<< 1) + e20;
      p5  = (e20 <<< 2) + e20;
      c7  = p7[19:4];
      c3  = p3[19:4];
      c5  = p5[19:4];
      c1  = e20[19:4];

      bits_o[c]  = bit_on;
      carry_d[c] = pos_i.ahead ? c7 : '0;
      back_o[c]  = sedd_pkg::sat16({{2{near_old[EW-1]}}, near_old} + {{2{c3[EW-1]}}, c3});
      near_d[c]  = sedd_pkg::sat16((pos_i.behind ? {{2{far_old[EW-1]}}, far_old} : 18'sd0)
                                   + {{2{c5[EW-1]}}, c5});
      far_d[c]   = pos_i.ahead ? c1 : '0;
    end
  end

  assign near_o = near_d;

  // clear at row end; drop down shares on the last row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      near_q  <= '0;
      far_q   <= '0;
    end else if (advance_i) begin
      if (!pos_i.ahead) begin
        carry_q <= '0;
        near_q  <= '0;
        far_q   <= '0;
      end else begin
        carry_q <= carry_d;
        near_q  <= pos_i.down ? near_d : '0;
        far_q   <= pos_i.down ? far_d : '0;
      end
    end
  end

endmodule

### hw/rtl/serpentine_error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// serpentine_error_diffusion_dither: serpentine Floyd-Steinberg RGB dither
// Top level: word handshakes, line buffer access, forwarding, result register.
// ----------------------------------------------------------------------------
// Takes one RGB pixel word per clock while the output does not stall, in
// serpentine order (even rows left to right, odd rows right to left), and
// returns one word per pixel with three dithered bits, the pixel's column and
// row and a frame_end flag on the last pixel of the frame. Throughput is one
// pixel per clock without back-pressure; a word passes the diffusion stage and
// then the result register. The rate is set by the sideways error loop: each
// pixel needs the 7/16 share of the one before it, so threshold, error and
// carry share one stage. The down errors of the row above sit in a 1024 x
// 48-bit line buffer with one read and one write port; the write for the
// turning column goes through a delay register and is forwarded to the first
// pixel of the next row. The buffer is not cleared: the first row of a frame
// reads it as zero, and every later row reads only columns that the row above
// wrote. Program image_width (register 0) and image_height (register 1) only
// while no pixel is in flight; values of zero or above 1024 are clamped.
// ----------------------------------------------------------------------------
module serpentine_error_diffusion_dither (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sedd_pkg::pix_in_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output sedd_pkg::pix_out_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [sedd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sedd_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam int AW = sedd_pkg::AddrW;

  // handshake and stage control
  logic accept, out_free, b_leave, b_free;
  logic b_valid_q, out_valid_q;

  // scan position of the word at the input
  sedd_pkg::scan_t scan_pos;

  // diffusion stage payload
  sedd_pkg::pix_in_t  b_pix_q;
  sedd_pkg::scan_t    b_pos_q;
  logic               fwd_q, fwd_d;
  sedd_pkg::err_vec_t fwd_data_q, fwd_data_d;

  // line buffer ports
  sedd_pkg::err_vec_t ram_rdata, line_val, ram_wdata;
  logic [AW-1:0]      ram_waddr, bx;
  logic               ram_we, bx_we, last_down;

  // delayed write of the turning column
  logic               dw_valid_q;
  logic [AW-1:0]      dw_addr_q;
  sedd_pkg::err_vec_t dw_data_q;

  // diffusion results
  logic [sedd_pkg::ChanNum-1:0] bits;
  sedd_pkg::err_vec_t           back_data, near_data;
  logic                         fwd_live, fwd_held;

  sedd_pkg::pix_out_t out_data_q, out_data_d;

  // Advance the stage when the result register is empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign b_leave    = b_valid_q && out_free;
  assign b_free     = !b_valid_q || b_leave;
  assign in_ready_o = b_free;
  assign accept     = in_valid_i && b_free;

  sedd_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .advance_i  (accept),
    .pos_o      (scan_pos)
  );

  // Write-back addressing. The pixel behind, in processing order, gets its
  // finished down error now; the turning column's value is registered and
  // written once the stage holds no pixel or a first-of-row pixel, which writes nothing.
  assign last_down = !b_pos_q.ahead && b_pos_q.down;
  assign bx        = b_pos_q.y[0] ? (b_pos_q.x + AW'(1)) : (b_pos_q.x - AW'(1));
  assign bx_we     = b_leave && b_pos_q.down && b_pos_q.behind;
  assign ram_we    = dw_valid_q || bx_we;
  assign ram_waddr = dw_valid_q ? dw_addr_q : bx;
  assign ram_wdata = dw_valid_q ? dw_data_q : back_data;

  sedd_line_ram u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(scan_pos.x),
    .rdata_o(ram_rdata)
  );

  // Forward the turning column's value to a read that would miss it: either
  // the value is still being computed, or its write lands at this edge.
  assign fwd_live   = b_leave && last_down && (b_pos_q.x == scan_pos.x);
  assign fwd_held   = dw_valid_q && (dw_addr_q == scan_pos.x);
  assign fwd_d      = fwd_live || fwd_held;
  assign fwd_data_d = fwd_live ? near_data : dw_data_q;
  assign line_val   = fwd_q ? fwd_data_q : ram_rdata;

  sedd_diffuse u_diffuse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(b_leave),
    .pix_i    (b_pix_q),
    .pos_i    (b_pos_q),
    .line_i   (line_val),
    .bits_o   (bits),
    .back_o   (back_data),
    .near_o   (near_data)
  );

  always_comb begin
    out_data_d.red_on    = bits[0];
    out_data_d.green_on  = bits[1];
    out_data_d.blue_on   = bits[2];
    out_data_d.column    = b_pos_q.x;
    out_data_d.row       = b_pos_q.y;
    out_data_d.frame_end = !b_pos_q.ahead && !b_pos_q.down;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      dw_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        b_valid_q <= 1'b1;
      end else if (b_leave) begin
        b_valid_q <= 1'b0;
      end
      if (b_leave) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      dw_valid_q <= b_leave && last_down;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_pix_q    <= in_data_i;
      b_pos_q    <= scan_pos;
      fwd_q      <= fwd_d;
      fwd_data_q <= fwd_data_d;
    end
    if (b_leave) begin
      out_data_q <= out_data_d;
      dw_addr_q  <= b_pos_q.x;
      dw_data_q  <= near_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  // the delayed write never meets a write of the pixel behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dw_valid_q && bx_we))
    else $error("line buffer write port conflict");

  // a delayed write follows the turning pixel leaving the stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_leave && last_down |=> dw_valid_q && (dw_addr_q == $past(b_pos_q.x)))
    else $error("turning column write lost");

  // only the first pixel of a row picks up a forwarded value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fwd_d |-> !scan_pos.behind)
    else $error("forward hit inside a row");

  // an accepted word always occupies the stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> b_valid_q)
    else $error("accepted word dropped");
`endif

endmodule
